// ===== hdl/dd_pkg.sv =====
// ----------------------------------------------------------------------------
// dd_pkg
// shared types, status codes and calendar tables for the date difference block
// ----------------------------------------------------------------------------
`default_nettype none

package dd_pkg;

    localparam int unsigned DAY_W    = 5;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned COUNT_W  = 22;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CENT_W   = 8;
    localparam int unsigned CUM_W    = 9;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_BEFORE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID    = 2'd2;

    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_LEAP,
        S_SUM,
        S_FIN
    } t_state;

    typedef struct packed {
        logic capture;
        logic div;
        logic leap;
        logic sum;
        logic finish;
        logic sel;
    } t_cmd;

    // days of the month outside february, for months 1..12
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    // days in the year before the first of the month, common year
    function automatic logic [CUM_W-1:0] cum_days(input logic [MONTH_W-1:0] m);
        logic [CUM_W-1:0] c;
        case (m)
            4'd2:    c = 9'd31;
            4'd3:    c = 9'd59;
            4'd4:    c = 9'd90;
            4'd5:    c = 9'd120;
            4'd6:    c = 9'd151;
            4'd7:    c = 9'd181;
            4'd8:    c = 9'd212;
            4'd9:    c = 9'd243;
            4'd10:   c = 9'd273;
            4'd11:   c = 9'd304;
            4'd12:   c = 9'd334;
            default: c = 9'd0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/dd_ctrl.sv =====
// ----------------------------------------------------------------------------
// dd_ctrl
// sequencer: takes a request, steps the datapath through both dates, hands off
// ----------------------------------------------------------------------------
`default_nettype none

module dd_ctrl
    import dd_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  wire  i_out_ready,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_sel, n_sel;
    logic   r_out_full, n_out_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_sel      <= 1'b0;
            r_out_full <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_sel      <= n_sel;
            r_out_full <= n_out_full;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_sel      = r_sel;
        n_out_full = r_out_full && !i_out_ready;
        o_cmd      = '0;
        o_cmd.sel  = r_sel;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_sel         = 1'b0;
                    n_state       = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                n_state   = S_LEAP;
            end
            S_LEAP: begin
                o_cmd.leap = 1'b1;
                n_state    = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                if (!r_sel) begin
                    n_sel   = 1'b1;
                    n_state = S_DIV;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // wait for the output register to drain
                if (!r_out_full || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_out_full   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_full;

endmodule

`default_nettype wire

// ===== hdl/dd_dpath.sv =====
// ----------------------------------------------------------------------------
// dd_dpath
// day number datapath: century split, leap test, serial day sum, final compare
// ----------------------------------------------------------------------------
`default_nettype none

module dd_dpath
    import dd_pkg::*;
(
    input  wire                  i_clk,
    input  t_cmd                 i_cmd,
    input  wire  [47:0]          i_data,
    input  wire                  i_inc,
    output logic [COUNT_W-1:0]   o_count,
    output logic [STATUS_W-1:0]  o_status
);

    logic [DAY_W-1:0]    r_sd, r_ed;
    logic [MONTH_W-1:0]  r_sm, r_em;
    logic [YEAR_W-1:0]   r_sy, r_ey;
    logic                r_inc;
    logic                r_ok;
    logic [CENT_W-1:0]   r_qy, r_qp;
    logic [COUNT_W-1:0]  r_base;
    logic [CUM_W-1:0]    r_cum;
    logic                r_adj;
    logic [COUNT_W-1:0]  r_dn_a, r_dn_b;
    logic [COUNT_W-1:0]  r_count;
    logic [STATUS_W-1:0] r_status;

    logic [DAY_W-1:0]    cur_d;
    logic [MONTH_W-1:0]  cur_m;
    logic [YEAR_W-1:0]   cur_y, cur_py;
    logic [26:0]         prod_y, prod_p;
    logic [22:0]         prod_365;
    logic [YEAR_W-1:0]   rem100;
    logic                leap;
    logic [DAY_W-1:0]    dim;
    logic                date_ok;
    logic [COUNT_W-1:0]  day_num;

    assign cur_d  = i_cmd.sel ? r_ed : r_sd;
    assign cur_m  = i_cmd.sel ? r_em : r_sm;
    assign cur_y  = i_cmd.sel ? r_ey : r_sy;
    assign cur_py = cur_y - 14'd1;

    // divide by 100 through the reciprocal 5243 / 2^19
    assign prod_y   = 27'(cur_y) * 27'd5243;
    assign prod_p   = 27'(cur_py) * 27'd5243;
    assign prod_365 = 23'(cur_py) * 23'd365;

    assign rem100 = cur_y - 14'(15'(r_qy) * 15'd100);
    assign leap   = ((cur_y[1:0] == 2'd0) && (rem100 != '0)) ||
                    ((rem100 == '0) && (r_qy[1:0] == 2'd0));
    assign dim    = (cur_m == MONTH_FEB) ? (leap ? 5'd29 : 5'd28) : month_len(cur_m);
    assign date_ok = (cur_y >= 14'd1) && (cur_y <= YEAR_MAX) &&
                     (cur_m >= 4'd1) && (cur_m <= 4'd12) &&
                     (cur_d >= 5'd1) && (cur_d <= dim);

    assign day_num = r_base + 22'(cur_py >> 2) - 22'(r_qp) + 22'(r_qp >> 2)
                   + 22'(r_cum) + 22'(r_adj) + 22'(cur_d);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sd  <= i_data[4:0];
            r_sm  <= i_data[8:5];
            r_sy  <= i_data[22:9];
            r_ed  <= i_data[27:23];
            r_em  <= i_data[31:28];
            r_ey  <= i_data[45:32];
            r_inc <= i_inc;
            r_ok  <= 1'b1;
        end
        if (i_cmd.div) begin
            r_qy <= prod_y[26:19];
            r_qp <= prod_p[26:19];
        end
        if (i_cmd.leap) begin
            r_base <= prod_365[COUNT_W-1:0];
            r_cum  <= cum_days(cur_m);
            r_adj  <= leap && (cur_m > MONTH_FEB);
            r_ok   <= r_ok && date_ok;
        end
        if (i_cmd.sum) begin
            if (i_cmd.sel) begin
                r_dn_b <= day_num;
            end else begin
                r_dn_a <= day_num;
            end
        end
        if (i_cmd.finish) begin
            if (!r_ok) begin
                r_count  <= '0;
                r_status <= ST_INVALID;
            end else if (r_dn_a >= r_dn_b) begin
                r_count  <= '0;
                r_status <= ST_NOT_BEFORE;
            end else begin
                r_count  <= r_dn_b - r_dn_a + 22'(r_inc);
                r_status <= ST_OK;
            end
        end
    end

    assign o_count  = r_count;
    assign o_status = r_status;

endmodule

`default_nettype wire

// ===== hdl/date_difference_in_days.sv =====
// ----------------------------------------------------------------------------
// date_difference_in_days
// days between two gregorian dates, with range and ordering checks
// ----------------------------------------------------------------------------
// One request carries a start and an end date and an include-end-day flag and
// gives one result: the day count and a status (ok, start not before end,
// invalid date). A request holds the block from the accepting cycle through
// the century split, leap test and day number sum steps for each date in turn,
// all through a single shared datapath, and then the final compare, which
// writes the result into the output register. No new request is taken until
// the block is done with the last one. The next request is taken while a
// result still waits in the output register. If the previous result is still
// waiting when the next one is done, the block holds in its final step until
// the output drains.
`default_nettype none

module date_difference_in_days
    import dd_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // start_day, start_month, start_year, end_day, end_month, end_year, zero pad
    input  wire  [47:0] i_s_axis_tdata,
    // include_end_day
    input  wire         i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    // day_count, zero pad
    output logic [23:0] o_m_axis_tdata,
    // status
    output logic [1:0]  o_m_axis_tuser
);

    t_cmd                cmd;
    logic [COUNT_W-1:0]  count;
    logic [STATUS_W-1:0] status;

    dd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (cmd)
    );

    dd_dpath u_dpath (
        .i_clk    (i_clk),
        .i_cmd    (cmd),
        .i_data   (i_s_axis_tdata),
        .i_inc    (i_s_axis_tuser),
        .o_count  (count),
        .o_status (status)
    );

    assign o_m_axis_tdata = {2'b00, count};
    assign o_m_axis_tuser = status;

    a_no_status3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser != 2'd3))
        else $error("status code 3 on output");

    a_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser != ST_OK)) |-> (o_m_axis_tdata == '0))
        else $error("nonzero count with error status");

    a_ok_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == ST_OK)) |-> (o_m_axis_tdata != '0))
        else $error("zero count with ok status");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("second request taken while busy");

endmodule

`default_nettype wire
